[src/svfpdr_pkg.sv]
// Shared types, codes and helper functions for the state-variable filter
// with the phase-distortion ring. No dependencies.
`default_nettype none

package svfpdr_pkg;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    REG_COEF_A1    = 3'd0,
    REG_COEF_A2    = 3'd1,
    REG_COEF_A3    = 3'd2,
    REG_RING_GAIN  = 3'd3,
    REG_RING_STEP  = 3'd4,
    REG_FUND_STEP  = 3'd5,
    REG_WARP       = 3'd6,
    REG_ENV_REL    = 3'd7
  } reg_idx_e;

  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 31;

  // Default values of the top-level parameters.
  localparam int          SampleWidthDef = 24;
  localparam int          SineDepthDef   = 1024;
  localparam logic [29:0] EnvAttackDef   = 30'd1051603149;

  // Fixed-point constants.
  localparam logic [30:0] OneQ30      = 31'd1073741824;
  localparam logic [16:0] OneQ16      = 17'd65536;
  localparam logic [30:0] WarpSlope   = 31'd2104533975;
  localparam int          DivSteps    = 31;
  localparam int          DivCntW     = 5;

  // Controller states: one per step of the sample schedule.
  typedef enum logic [4:0] {
    ST_IDLE, ST_F1, ST_F2, ST_V1, ST_F3, ST_F4, ST_V2, ST_IC2,
    ST_E1, ST_E2, ST_ENV, ST_WIN, ST_SCALE, ST_WARP, ST_M, ST_DSET,
    ST_DIV, ST_SIDX, ST_SRD, ST_RMUL, ST_RING, ST_GMUL, ST_OUT
  } state_e;

  // Datapath operations.
  typedef enum logic [4:0] {
    OP_NONE, OP_LOAD, OP_F1, OP_F2, OP_V1, OP_F3, OP_F4, OP_V2, OP_IC2,
    OP_E1, OP_E2, OP_ENV, OP_WIN, OP_SCALE, OP_WARP, OP_M, OP_DSET,
    OP_DIV, OP_SIDX, OP_SRD, OP_RMUL, OP_RING, OP_GMUL, OP_OUT
  } op_e;

  typedef struct packed {
    op_e op;
  } dp_cmd_t;

  typedef struct packed {
    logic                we;
    logic [CfgIdxW-1:0]  idx;
    logic [CfgDataW-1:0] data;
  } cfg_wr_t;

  // Saturate a wide signed value to signed 32 bits.
  function automatic logic signed [31:0] sat32(logic signed [39:0] v);
    logic signed [31:0] r;
    if (v > 40'sd2147483647) begin
      r = 32'sh7FFFFFFF;
    end else if (v < -40'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

[src/svfpdr_ctrl.sv]
// Sequencer for one sample: steps the datapath through the filter, envelope,
// phase, divider and sine schedule. Depends on svfpdr_pkg.
`default_nettype none

module svfpdr_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output svfpdr_pkg::dp_cmd_t    cmd_o
);
  import svfpdr_pkg::*;

  state_e               state_q, state_d;
  logic [DivCntW-1:0]   cnt_q, cnt_d;
  logic                 out_valid_q, out_valid_d;
  logic                 out_free;
  logic                 div_last;

  assign out_free = !out_valid_q || !out_stall_i;
  assign div_last = (cnt_q == DivCntW'(DivSteps - 1));

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (in_valid_i) state_d = ST_F1;
      ST_F1:    state_d = ST_F2;
      ST_F2:    state_d = ST_V1;
      ST_V1:    state_d = ST_F3;
      ST_F3:    state_d = ST_F4;
      ST_F4:    state_d = ST_V2;
      ST_V2:    state_d = ST_IC2;
      ST_IC2:   state_d = ST_E1;
      ST_E1:    state_d = ST_E2;
      ST_E2:    state_d = ST_ENV;
      ST_ENV:   state_d = ST_WIN;
      ST_WIN:   state_d = ST_SCALE;
      ST_SCALE: state_d = ST_WARP;
      ST_WARP:  state_d = ST_M;
      ST_M:     state_d = ST_DSET;
      ST_DSET:  state_d = ST_DIV;
      ST_DIV:   if (div_last) state_d = ST_SIDX;
      ST_SIDX:  state_d = ST_SRD;
      ST_SRD:   state_d = ST_RMUL;
      ST_RMUL:  state_d = ST_RING;
      ST_RING:  state_d = ST_GMUL;
      ST_GMUL:  state_d = ST_OUT;
      ST_OUT:   if (out_free) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // Outputs to the datapath and the handshakes.
  always_comb begin
    cmd_o.op    = OP_NONE;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q && out_stall_i;
    case (state_q)
      ST_IDLE:  if (in_valid_i) cmd_o.op = OP_LOAD;
      ST_F1:    cmd_o.op = OP_F1;
      ST_F2:    cmd_o.op = OP_F2;
      ST_V1:    cmd_o.op = OP_V1;
      ST_F3:    cmd_o.op = OP_F3;
      ST_F4:    cmd_o.op = OP_F4;
      ST_V2:    cmd_o.op = OP_V2;
      ST_IC2:   cmd_o.op = OP_IC2;
      ST_E1:    cmd_o.op = OP_E1;
      ST_E2:    cmd_o.op = OP_E2;
      ST_ENV:   cmd_o.op = OP_ENV;
      ST_WIN:   cmd_o.op = OP_WIN;
      ST_SCALE: cmd_o.op = OP_SCALE;
      ST_WARP:  cmd_o.op = OP_WARP;
      ST_M:     cmd_o.op = OP_M;
      ST_DSET: begin
        cmd_o.op = OP_DSET;
        cnt_d    = '0;
      end
      ST_DIV: begin
        cmd_o.op = OP_DIV;
        cnt_d    = cnt_q + DivCntW'(1);
      end
      ST_SIDX:  cmd_o.op = OP_SIDX;
      ST_SRD:   cmd_o.op = OP_SRD;
      ST_RMUL:  cmd_o.op = OP_RMUL;
      ST_RING:  cmd_o.op = OP_RING;
      ST_GMUL:  cmd_o.op = OP_GMUL;
      ST_OUT: begin
        if (out_free) begin
          cmd_o.op    = OP_OUT;
          out_valid_d = 1'b1;
        end
      end
      default:  cmd_o.op = OP_NONE;
    endcase
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // An accepted word starts the schedule on the next cycle.
  a_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> state_q == ST_F1)
    else $error("schedule did not start after accept");

  // The divider runs exactly its step count before the sine lookup.
  a_div_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV && div_last) |=> state_q == ST_SIDX)
    else $error("divider overran its step count");

  // A new result only appears from the output step.
  a_out_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == ST_OUT)
    else $error("result raised outside the output step");

endmodule

`default_nettype wire

[src/svfpdr_dpath.sv]
// Datapath: configuration registers, filter and oscillator state, one shared
// multiplier, a bit-serial divider and the quarter-wave sine table.
// Depends on svfpdr_pkg.
`default_nettype none

module svfpdr_dpath #(
  parameter int          SampleWidth    = svfpdr_pkg::SampleWidthDef,
  parameter int          SineTableDepth = svfpdr_pkg::SineDepthDef,
  parameter logic [29:0] EnvAttackCoef  = svfpdr_pkg::EnvAttackDef
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire svfpdr_pkg::cfg_wr_t           cfg_i,
  input  wire svfpdr_pkg::dp_cmd_t           cmd_i,
  input  wire logic signed [SampleWidth-1:0] sample_in_i,
  output logic signed [SampleWidth-1:0]      sample_out_o
);
  import svfpdr_pkg::*;

  localparam int IdxW  = $clog2(SineTableDepth + 1);
  localparam int ProdW = 31 + IdxW;
  localparam logic [63:0] HalfPiQ30 = 64'd1686629713;
  localparam logic signed [37:0] SMax = (38'sd1 <<< (SampleWidth - 1)) - 38'sd1;
  localparam logic signed [37:0] SMin = -SMax - 38'sd1;

  // Divisor of each series term, (2n)(2n+1).
  localparam longint unsigned TaylorDiv [1:9] = '{
    64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210, 64'd272, 64'd342
  };

  typedef logic [30:0] sine_rom_t [SineTableDepth+1];

  // Quarter-wave sine in Q1.30 by a fixed-point Taylor series, built at
  // elaboration.
  function automatic sine_rom_t build_rom();
    sine_rom_t   rom;
    longint unsigned x, x2, t;
    longint      sum;
    for (int k = 0; k <= SineTableDepth; k++) begin
      x   = (longint'(k) * HalfPiQ30 + longint'(SineTableDepth / 2)) / SineTableDepth;
      x2  = (x * x) >> 30;
      t   = x;
      sum = longint'(x);
      for (int n = 1; n <= 9; n++) begin
        t = ((t * x2) >> 30) / TaylorDiv[n];
        if (n[0]) sum = sum - longint'(t);
        else      sum = sum + longint'(t);
      end
      if (sum < 0) sum = 0;
      if (sum > 64'sd1073741824) sum = 64'sd1073741824;
      rom[k] = sum[30:0];
    end
    return rom;
  endfunction

  localparam sine_rom_t SineRom = build_rom();

  // Configuration registers.
  logic [30:0] a1_q, a2_q, a3_q, rstep_q, fstep_q;
  logic [16:0] gain_q, warp_q;
  logic [29:0] rel_q;

  // Persistent state.
  logic signed [31:0] ic1_q, ic2_q;
  logic [31:0]        level_q, rp_q, fp_q;

  // Per-sample working registers.
  logic signed [32:0] v3_q;
  logic signed [34:0] v1_q;
  logic signed [35:0] v2_q;
  logic [31:0]        mag_q, scale_q, m_q, den_q, rem_q;
  logic [29:0]        c_q;
  logic [30:0]        quo_q, sine_q;
  logic               hi_q;
  logic [1:0]         quad_q;
  logic [IdxW-1:0]    idx_q;
  logic signed [33:0] ring_q;
  logic signed [67:0] p_q, acc_q;
  logic signed [SampleWidth-1:0] out_q;

  logic signed [33:0] ma, mb;
  logic signed [67:0] p_d, sum_ap, sum_r30;
  logic [32:0]        window, rem_sh;
  logic               ge;
  logic [32:0]        fsum;
  logic [31:0]        rp_base;
  logic signed [34:0] v1_abs;
  logic [62:0]        env_sum;
  logic [ProdW-1:0]   iprod;
  logic [IdxW-1:0]    iraw;
  logic signed [67:0] p_r16;
  logic signed [37:0] y;
  logic [31:0]        w;

  // Shared multiplier operand selection.
  assign window = 33'h100000000 - {1'b0, fp_q};
  always_comb begin
    ma = '0;
    mb = '0;
    case (cmd_i.op)
      OP_F1:   begin ma = $signed({3'b0, a1_q}); mb = 34'(ic1_q); end
      OP_F3:   begin ma = $signed({3'b0, a2_q}); mb = 34'(ic1_q); end
      OP_F2:   begin ma = $signed({3'b0, a2_q}); mb = 34'(v3_q); end
      OP_F4:   begin ma = $signed({3'b0, a3_q}); mb = 34'(v3_q); end
      OP_E1:   begin ma = $signed({4'b0, c_q}); mb = $signed({2'b0, level_q}); end
      OP_E2: begin
        ma = $signed({3'b0, OneQ30 - {1'b0, c_q}});
        mb = $signed({2'b0, mag_q});
      end
      OP_WIN:  begin ma = $signed({2'b0, level_q}); mb = $signed({1'b0, window}); end
      OP_WARP: begin ma = $signed({17'b0, warp_q}); mb = $signed({3'b0, WarpSlope}); end
      OP_RMUL: begin
        ma = $signed({2'b0, scale_q});
        mb = quad_q[1] ? -$signed({3'b0, sine_q}) : $signed({3'b0, sine_q});
      end
      OP_GMUL: begin ma = $signed({17'b0, gain_q}); mb = ring_q; end
      default: begin ma = '0; mb = '0; end
    endcase
  end
  assign p_d = ma * mb;

  // Rounded sum of the two filter products.
  assign sum_ap  = acc_q + p_q;
  assign sum_r30 = (sum_ap + 68'sd536870912) >>> 30;
  assign v1_abs  = v1_q[34] ? -v1_q : v1_q;
  assign env_sum = 63'(acc_q) + 63'(p_q) + 63'd536870912;

  // Phase accumulators: a carry of the fundamental resets the ring.
  assign fsum    = {1'b0, fp_q} + {2'b0, fstep_q};
  assign rp_base = (fstep_q != '0 && fsum[32]) ? 32'd0 : rp_q;

  // One restoring divider step.
  assign rem_sh = {rem_q, 1'b0};
  assign ge     = rem_sh >= {1'b0, den_q};

  // Sine index from the warped phase.
  assign w     = {hi_q, quo_q};
  assign iprod = ProdW'(w[29:0]) * ProdW'(SineTableDepth) + (ProdW'(1) << 29);
  assign iraw  = iprod[30 +: IdxW];

  // Output sum.
  assign p_r16 = (p_q + 68'sd32768) >>> 16;
  assign y     = 38'(v2_q) + 38'(p_r16[52:0]);

  // Configuration and persistent state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a1_q    <= OneQ30;
      a2_q    <= '0;
      a3_q    <= '0;
      gain_q  <= '0;
      rstep_q <= '0;
      fstep_q <= '0;
      warp_q  <= '0;
      rel_q   <= '0;
      ic1_q   <= '0;
      ic2_q   <= '0;
      level_q <= '0;
      rp_q    <= '0;
      fp_q    <= '0;
    end else begin
      if (cfg_i.we) begin
        case (cfg_i.idx)
          REG_COEF_A1:   a1_q    <= (cfg_i.data > OneQ30) ? OneQ30 : cfg_i.data;
          REG_COEF_A2:   a2_q    <= (cfg_i.data > OneQ30) ? OneQ30 : cfg_i.data;
          REG_COEF_A3:   a3_q    <= (cfg_i.data > OneQ30) ? OneQ30 : cfg_i.data;
          REG_RING_GAIN: gain_q  <= (cfg_i.data[16:0] > OneQ16) ? OneQ16 : cfg_i.data[16:0];
          REG_RING_STEP: rstep_q <= cfg_i.data;
          REG_FUND_STEP: fstep_q <= cfg_i.data;
          REG_WARP:      warp_q  <= (cfg_i.data[16:0] > OneQ16) ? OneQ16 : cfg_i.data[16:0];
          REG_ENV_REL:   rel_q   <= cfg_i.data[29:0];
          default:       ;
        endcase
      end
      case (cmd_i.op)
        OP_V2:  ic1_q <= sat32(40'(2 * 40'(v1_q) - 40'(ic1_q)));
        OP_IC2: ic2_q <= sat32(40'(2 * 40'(v2_q) - 40'(ic2_q)));
        OP_ENV: begin
          level_q <= (env_sum[62:62] != '0 || env_sum[61:30] == '1 && env_sum[62])
                     ? 32'hFFFFFFFF : env_sum[61:30];
          if (fstep_q != '0) begin
            fp_q <= fsum[31:0];
          end
          rp_q <= rp_base + {1'b0, rstep_q};
        end
        default: ;
      endcase
    end
  end

  // Working registers of the schedule. The product is held while the
  // sequencer waits, so a stalled output step still sees the gain product.
  always_ff @(posedge clk_i) begin
    if (cmd_i.op != OP_NONE) p_q <= p_d;
    case (cmd_i.op)
      OP_LOAD:  v3_q <= 33'(sample_in_i) - 33'(ic2_q);
      OP_F2:    acc_q <= p_q;
      OP_F4:    acc_q <= p_q;
      OP_E2:    acc_q <= p_q;
      OP_V1:    v1_q <= sum_r30[34:0];
      OP_V2: begin
        v2_q  <= 36'(ic2_q) + 36'($signed(sum_r30[34:0]));
        mag_q <= v1_abs[34:32] != '0 ? 32'hFFFFFFFF : v1_abs[31:0];
      end
      OP_IC2:   c_q <= (mag_q > level_q) ? EnvAttackCoef : rel_q;
      OP_SCALE: scale_q <= (fstep_q != '0) ? p_q[63:32] : level_q;
      OP_M:     m_q <= 32'h80000000 - 32'((p_q[47:0] + 48'd32768) >> 16);
      OP_DSET: begin
        quo_q <= '0;
        if (rp_q < m_q) begin
          rem_q <= rp_q;
          den_q <= m_q;
          hi_q  <= 1'b0;
        end else begin
          rem_q <= rp_q - m_q;
          den_q <= 32'(33'h100000000 - {1'b0, m_q});
          hi_q  <= 1'b1;
        end
      end
      OP_DIV: begin
        rem_q <= ge ? 32'(rem_sh - {1'b0, den_q}) : rem_sh[31:0];
        quo_q <= {quo_q[29:0], ge};
      end
      OP_SIDX: begin
        quad_q <= w[31:30];
        idx_q  <= w[30] ? IdxW'(SineTableDepth) - iraw : iraw;
      end
      OP_SRD:   sine_q <= SineRom[idx_q];
      OP_RING:  ring_q <= 34'((p_q + 68'sd536870912) >>> 30);
      OP_OUT: begin
        if (y > SMax)      out_q <= SMax[SampleWidth-1:0];
        else if (y < SMin) out_q <= SMin[SampleWidth-1:0];
        else               out_q <= y[SampleWidth-1:0];
      end
      default: ;
    endcase
  end

  assign sample_out_o = out_q;

endmodule

`default_nettype wire

[src/svf_phase_distortion_resonator.sv]
// Top level of the state-variable filter with the phase-distortion ring.
// Instantiates svfpdr_ctrl and svfpdr_dpath; depends on svfpdr_pkg.
//
// Each accepted sample runs a two-integrator trapezoidal filter, an envelope
// follower and a phase-distorted, optionally hard-synced sine ring, and
// returns lowpass plus gained ring, saturated. The result is registered at
// the end of the schedule, once any earlier result has been taken; a new
// sample is taken in the cycle after that, and not before. The schedule is
// set by the single shared 34x34 multiplier, used in sequence for ten
// products, and the 31-step bit-serial divider of the phase-distortion map.
// The result register lets the next sample be accepted while a result still
// waits. The user must write configuration only while no sample is in
// flight; the block itself does not enforce it.
`default_nettype none

module svf_phase_distortion_resonator #(
  parameter int          SAMPLE_WIDTH     = svfpdr_pkg::SampleWidthDef,
  parameter int          SINE_TABLE_DEPTH = svfpdr_pkg::SineDepthDef,
  parameter logic [29:0] ENV_ATTACK_COEF  = svfpdr_pkg::EnvAttackDef
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                cfg_we_i,
  input  wire logic [svfpdr_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  wire logic [svfpdr_pkg::CfgDataW-1:0]     cfg_data_i,
  input  wire logic                                in_valid_i,
  output logic                                     in_stall_o,
  input  wire logic signed [SAMPLE_WIDTH-1:0]      sample_in_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_stall_i,
  output logic signed [SAMPLE_WIDTH-1:0]           sample_out_o
);
  import svfpdr_pkg::*;

  cfg_wr_t cfg;
  dp_cmd_t cmd;

  assign cfg.we   = cfg_we_i;
  assign cfg.idx  = cfg_index_i;
  assign cfg.data = cfg_data_i;

  // Sequencer.
  svfpdr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  // Arithmetic and state.
  svfpdr_dpath #(
    .SampleWidth    (SAMPLE_WIDTH),
    .SineTableDepth (SINE_TABLE_DEPTH),
    .EnvAttackCoef  (ENV_ATTACK_COEF)
  ) u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .cmd_i        (cmd),
    .sample_in_i  (sample_in_i),
    .sample_out_o (sample_out_o)
  );

endmodule

`default_nettype wire
